@@ hw/rtl/lfpd_pkg.sv @@
// Shared types, constants and the helper function of the line follower PID drive.
`default_nettype none

package lfpd_pkg;

  // Sensor array and datapath sizes.
  localparam int SENSOR_COUNT = 11;
  localparam int SAMPLE_BITS  = 12;
  localparam int DUTY_BITS    = 10;
  localparam int THRESH_BITS  = 12;
  localparam int GAIN_BITS    = 16;
  localparam int ERR_BITS     = 5;
  localparam int INTEG_BITS   = 16;

  // Configuration port sizes.
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 16;

  // Stream payload sizes, padded to whole bytes.
  localparam int IN_BITS    = SENSOR_COUNT * SAMPLE_BITS + 1;
  localparam int IN_TDATA_W = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS   = 2 * DUTY_BITS + 4 + 2 + ERR_BITS;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  // PID arithmetic widths.
  localparam int PROD_P_W = GAIN_BITS + ERR_BITS + 1;
  localparam int DIFF_W   = ERR_BITS + 1;
  localparam int PROD_D_W = GAIN_BITS + DIFF_W + 2;
  localparam int PROD_I_W = GAIN_BITS + INTEG_BITS + 2;
  localparam int ACC_W    = PROD_I_W + 2;
  localparam int U_W      = ACC_W - 8;
  localparam int SPD_W    = U_W + 1;

  // Register reset values.
  localparam logic [THRESH_BITS-1:0] THRESH_RESET = THRESH_BITS'(4000);
  localparam logic [DUTY_BITS-1:0]   MAX_RESET    = DUTY_BITS'(455);
  localparam logic [DUTY_BITS-1:0]   BASE_RESET   = '0;
  localparam logic [GAIN_BITS-1:0]   GAIN_P_RESET = GAIN_BITS'(26112);
  localparam logic [GAIN_BITS-1:0]   GAIN_I_RESET = '0;
  localparam logic [GAIN_BITS-1:0]   GAIN_D_RESET = GAIN_BITS'(58624);

  // Configuration register indexes.
  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_THRESHOLD = 3'd0,
    CFG_SPEED_LIMIT = 3'd1,
    CFG_BASE_SPEED = 3'd2,
    CFG_GAIN_P = 3'd3,
    CFG_GAIN_I = 3'd4,
    CFG_GAIN_D = 3'd5
  } cfg_index_t;

  // Operating mode of the sequencer.
  typedef enum logic [1:0] {
    MODE_STOPPED  = 2'd0,
    MODE_STARTING = 2'd1,
    MODE_RUN      = 2'd2
  } mode_t;

  // Side of the line last seen.
  typedef enum logic [1:0] {
    SIDE_CENTER = 2'd0,
    SIDE_RIGHT  = 2'd1,
    SIDE_LEFT   = 2'd2
  } side_t;

  // Configuration register set.
  typedef struct packed {
    logic [THRESH_BITS-1:0] detect_threshold;
    logic [DUTY_BITS-1:0]   speed_limit;
    logic [DUTY_BITS-1:0]   base_speed;
    logic [GAIN_BITS-1:0]   gain_p;
    logic [GAIN_BITS-1:0]   gain_i;
    logic [GAIN_BITS-1:0]   gain_d;
  } cfg_t;

  // Line decode result handed to the controller.
  typedef struct packed {
    logic                       any;
    logic signed [ERR_BITS-1:0] err;
  } line_hit_t;

  // One motor command.
  typedef struct packed {
    logic [DUTY_BITS-1:0] duty;
    logic                 pin;
  } drive_t;

  // One result item.
  typedef struct packed {
    logic                       running;
    logic signed [ERR_BITS-1:0] position_error;
    logic [1:0]                 side_class;
    logic                       line_found;
    logic                       right_pin;
    logic [DUTY_BITS-1:0]       right_duty;
    logic                       left_pin;
    logic [DUTY_BITS-1:0]       left_duty;
  } result_t;

  // Turns a signed speed into a clamped duty and a direction pin level.
  // A zero speed gives zero duty and keeps the pin.
  function automatic drive_t drive_motor(input logic signed [SPD_W-1:0] s,
                                         input logic [DUTY_BITS-1:0] mx,
                                         input logic pos_level,
                                         input logic pin_hold);
    drive_t                 d;
    logic signed [SPD_W-1:0] mx_s;
    logic signed [SPD_W-1:0] mag;
    mx_s = SPD_W'({1'b0, mx});
    mag  = -s;
    if (s == '0) begin
      d.duty = '0;
      d.pin  = pin_hold;
    end else if (s > 0) begin
      if (mx == '0) begin
        d.duty = '0;
        d.pin  = ~pos_level;
      end else begin
        d.duty = (s >= mx_s) ? mx : s[DUTY_BITS-1:0];
        d.pin  = pos_level;
      end
    end else begin
      d.duty = (mag >= mx_s) ? mx : mag[DUTY_BITS-1:0];
      d.pin  = ~pos_level;
    end
    return d;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/lfpd_cfg_regs.sv @@
// Configuration register file of the line follower PID drive.
`default_nettype none

module lfpd_cfg_regs (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_we,
  input  wire logic [lfpd_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [lfpd_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  output lfpd_pkg::cfg_t                          cfg
);

  // Register writes by index; indexes past the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.detect_threshold <= lfpd_pkg::THRESH_RESET;
      cfg.speed_limit      <= lfpd_pkg::MAX_RESET;
      cfg.base_speed       <= lfpd_pkg::BASE_RESET;
      cfg.gain_p           <= lfpd_pkg::GAIN_P_RESET;
      cfg.gain_i           <= lfpd_pkg::GAIN_I_RESET;
      cfg.gain_d           <= lfpd_pkg::GAIN_D_RESET;
    end else if (cfg_we) begin
      unique case (lfpd_pkg::cfg_index_t'(cfg_index))
        lfpd_pkg::CFG_THRESHOLD: begin
          cfg.detect_threshold <= cfg_data[lfpd_pkg::THRESH_BITS-1:0];
        end
        lfpd_pkg::CFG_SPEED_LIMIT: begin
          cfg.speed_limit <= cfg_data[lfpd_pkg::DUTY_BITS-1:0];
        end
        lfpd_pkg::CFG_BASE_SPEED: begin
          cfg.base_speed <= cfg_data[lfpd_pkg::DUTY_BITS-1:0];
        end
        lfpd_pkg::CFG_GAIN_P: begin
          cfg.gain_p <= cfg_data[lfpd_pkg::GAIN_BITS-1:0];
        end
        lfpd_pkg::CFG_GAIN_I: begin
          cfg.gain_i <= cfg_data[lfpd_pkg::GAIN_BITS-1:0];
        end
        lfpd_pkg::CFG_GAIN_D: begin
          cfg.gain_d <= cfg_data[lfpd_pkg::GAIN_BITS-1:0];
        end
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/lfpd_line_decode.sv @@
// Sensor thresholding and priority decode of the line position error.
`default_nettype none

module lfpd_line_decode (
  input  wire logic [lfpd_pkg::SENSOR_COUNT*lfpd_pkg::SAMPLE_BITS-1:0] samples,
  input  wire logic [lfpd_pkg::THRESH_BITS-1:0]                         threshold,
  output lfpd_pkg::line_hit_t                                           hit
);

  localparam int CMP_W = (lfpd_pkg::SAMPLE_BITS > lfpd_pkg::THRESH_BITS) ?
                         lfpd_pkg::SAMPLE_BITS : lfpd_pkg::THRESH_BITS;

  logic [lfpd_pkg::SENSOR_COUNT-1:0] seen;

  // Compare every sample against the threshold.
  always_comb begin
    for (int k = 0; k < lfpd_pkg::SENSOR_COUNT; k++) begin
      seen[k] = CMP_W'(samples[k*lfpd_pkg::SAMPLE_BITS +: lfpd_pkg::SAMPLE_BITS]) >
                CMP_W'(threshold);
    end
  end

  // Fixed priority rule: later matches override earlier ones, the center last.
  // Left sensors sit at odd indexes and give negative errors.
  always_comb begin
    logic signed [lfpd_pkg::ERR_BITS-1:0] e;
    e = '0;
    for (int i = 1; i <= 5; i++) begin
      if (seen[2*i-1]) e = lfpd_pkg::ERR_BITS'(-2 * i);
    end
    for (int i = 1; i <= 4; i++) begin
      if (seen[2*i-1] && seen[2*i+1]) e = lfpd_pkg::ERR_BITS'(-(2 * i + 1));
    end
    for (int i = 1; i <= 5; i++) begin
      if (seen[2*i]) e = lfpd_pkg::ERR_BITS'(2 * i);
    end
    for (int i = 1; i <= 4; i++) begin
      if (seen[2*i] && seen[2*i+2]) e = lfpd_pkg::ERR_BITS'(2 * i + 1);
    end
    if (seen[0]) e = '0;
    if (seen[0] && seen[1]) e = -lfpd_pkg::ERR_BITS'(1);
    if (seen[0] && seen[2]) e = lfpd_pkg::ERR_BITS'(1);
    hit.err = e;
    hit.any = |seen;
  end

endmodule

`default_nettype wire

@@ hw/rtl/lfpd_pid_drive.sv @@
// Mode sequencer, PID controller state and motor command logic.
`default_nettype none

module lfpd_pid_drive (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               commit,
  input  wire lfpd_pkg::cfg_t      cfg,
  input  wire lfpd_pkg::line_hit_t hit,
  input  wire logic               start_request,
  output lfpd_pkg::result_t       result
);

  localparam int SUM_W = lfpd_pkg::INTEG_BITS + 1;

  // Controller state.
  lfpd_pkg::mode_t                                mode, mode_next;
  lfpd_pkg::side_t                                side_state, side_state_next;
  logic signed [lfpd_pkg::ERR_BITS-1:0]           current_error, current_error_next;
  logic signed [lfpd_pkg::ERR_BITS-1:0]           previous_error, previous_error_next;
  logic signed [lfpd_pkg::INTEG_BITS-1:0]         error_integral, error_integral_next;
  lfpd_pkg::drive_t                               left_hold, left_hold_next;
  lfpd_pkg::drive_t                               right_hold, right_hold_next;

  // PID datapath.
  logic signed [SUM_W-1:0]                sum;
  logic signed [lfpd_pkg::INTEG_BITS-1:0] integ_sat;
  logic signed [lfpd_pkg::DIFF_W-1:0]     diff;
  logic signed [lfpd_pkg::PROD_P_W-1:0]   prod_p;
  logic signed [lfpd_pkg::PROD_I_W-1:0]   prod_i;
  logic signed [lfpd_pkg::PROD_D_W-1:0]   prod_d;
  logic signed [lfpd_pkg::ACC_W-1:0]      acc;
  logic signed [lfpd_pkg::ACC_W-1:0]      acc_rnd;
  logic signed [lfpd_pkg::U_W-1:0]        u;
  logic signed [lfpd_pkg::SPD_W-1:0]      base_s;
  logic signed [lfpd_pkg::SPD_W-1:0]      max_s;
  logic signed [lfpd_pkg::SPD_W-1:0]      left_spd, right_spd;
  logic                                   running;
  logic                                   line_found;

  // Integral update with 16-bit saturation.
  always_comb begin
    sum = SUM_W'(error_integral) + SUM_W'(hit.err);
    if (sum[SUM_W-1] != sum[SUM_W-2]) begin
      integ_sat = sum[SUM_W-1] ? {1'b1, {(lfpd_pkg::INTEG_BITS-1){1'b0}}}
                               : {1'b0, {(lfpd_pkg::INTEG_BITS-1){1'b1}}};
    end else begin
      integ_sat = sum[lfpd_pkg::INTEG_BITS-1:0];
    end
  end

  // Three gain products, their sum and the Q8.8 truncation toward zero.
  always_comb begin
    diff   = lfpd_pkg::DIFF_W'(hit.err) - lfpd_pkg::DIFF_W'(previous_error);
    prod_p = lfpd_pkg::PROD_P_W'(signed'({1'b0, cfg.gain_p})) *
             lfpd_pkg::PROD_P_W'(hit.err);
    prod_i = lfpd_pkg::PROD_I_W'(signed'({1'b0, cfg.gain_i})) *
             lfpd_pkg::PROD_I_W'(integ_sat);
    prod_d = lfpd_pkg::PROD_D_W'(signed'({1'b0, cfg.gain_d})) *
             lfpd_pkg::PROD_D_W'(diff);
    acc    = lfpd_pkg::ACC_W'(prod_p) + lfpd_pkg::ACC_W'(prod_i) +
             lfpd_pkg::ACC_W'(prod_d);
    acc_rnd = acc[lfpd_pkg::ACC_W-1] ? acc + lfpd_pkg::ACC_W'(255) : acc;
    u      = acc_rnd[lfpd_pkg::ACC_W-1:8];
    base_s = lfpd_pkg::SPD_W'({1'b0, cfg.base_speed});
    max_s  = lfpd_pkg::SPD_W'({1'b0, cfg.speed_limit});
  end

  // Speed selection: PID with the line seen, search speeds by side otherwise.
  always_comb begin
    if (hit.any) begin
      left_spd  = base_s - lfpd_pkg::SPD_W'(u);
      right_spd = base_s + lfpd_pkg::SPD_W'(u);
    end else begin
      unique case (side_state)
        lfpd_pkg::SIDE_LEFT: begin
          left_spd  = max_s;
          right_spd = -max_s;
        end
        lfpd_pkg::SIDE_RIGHT: begin
          left_spd  = -max_s;
          right_spd = max_s;
        end
        default: begin
          left_spd  = base_s;
          right_spd = base_s;
        end
      endcase
    end
  end

  // Mode sequencer and next state.
  always_comb begin
    mode_next           = mode;
    side_state_next     = side_state;
    current_error_next  = current_error;
    previous_error_next = previous_error;
    error_integral_next = error_integral;
    left_hold_next      = left_hold;
    right_hold_next     = right_hold;
    running             = 1'b0;
    line_found          = 1'b0;
    unique case (mode)
      lfpd_pkg::MODE_RUN: begin
        running         = 1'b1;
        left_hold_next  = lfpd_pkg::drive_motor(left_spd, cfg.speed_limit, 1'b1,
                                                left_hold.pin);
        right_hold_next = lfpd_pkg::drive_motor(right_spd, cfg.speed_limit, 1'b0,
                                                right_hold.pin);
        if (hit.any) begin
          line_found          = 1'b1;
          current_error_next  = hit.err;
          previous_error_next = hit.err;
          error_integral_next = integ_sat;
          if (hit.err >= -lfpd_pkg::ERR_BITS'(4) && hit.err <= lfpd_pkg::ERR_BITS'(4)) begin
            side_state_next = lfpd_pkg::SIDE_CENTER;
          end else if (hit.err >= lfpd_pkg::ERR_BITS'(5)) begin
            side_state_next = lfpd_pkg::SIDE_LEFT;
          end else begin
            side_state_next = lfpd_pkg::SIDE_RIGHT;
          end
        end
      end
      lfpd_pkg::MODE_STARTING: begin
        mode_next = lfpd_pkg::MODE_RUN;
      end
      default: begin
        left_hold_next.duty  = '0;
        right_hold_next.duty = '0;
        mode_next = start_request ? lfpd_pkg::MODE_STARTING : lfpd_pkg::MODE_STOPPED;
      end
    endcase
  end

  // State registers advance once per processed item.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= lfpd_pkg::MODE_STOPPED;
      side_state     <= lfpd_pkg::SIDE_CENTER;
      current_error  <= '0;
      previous_error <= '0;
      error_integral <= '0;
      left_hold      <= '0;
      right_hold     <= '0;
    end else if (commit) begin
      mode           <= mode_next;
      side_state     <= side_state_next;
      current_error  <= current_error_next;
      previous_error <= previous_error_next;
      error_integral <= error_integral_next;
      left_hold      <= left_hold_next;
      right_hold     <= right_hold_next;
    end
  end

  // Result reflects the state after this item.
  always_comb begin
    result.left_duty      = left_hold_next.duty;
    result.left_pin       = left_hold_next.pin;
    result.right_duty     = right_hold_next.duty;
    result.right_pin      = right_hold_next.pin;
    result.line_found     = line_found;
    result.side_class     = side_state_next;
    result.position_error = current_error_next;
    result.running        = running;
  end

endmodule

`default_nettype wire

@@ hw/rtl/line_follower_pid_drive_core.sv @@
// Top level of the line follower PID drive: stream handshake and result register.
//
// Usage: each transfer on the s_ channel is one control tick carrying eleven
// 12-bit reflectance samples and a start request. Each tick gives exactly one
// transfer on the m_ channel with both motor duties, direction pins, line
// status, side class, position error and the run flag.
// Configuration registers are written through cfg_we, cfg_index and cfg_data
// while no tick is in flight; each takes effect on the next tick.
// An input transfer's result passes through the input register, where decode, PID
// and drive logic run on its contents, and then the result register. One tick is
// accepted every cycle while the receiver does not stall; the rate is set by the
// controller update, whose state each tick feeds into the next.
// Reset (rst, synchronous) stops the motors, clears the PID state, loads
// the register defaults and empties both stages.
// When the receiver stalls, the result register holds and the input register
// fills; s_tready then drops until the result is taken.
`default_nettype none

module line_follower_pid_drive_core (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // Fields from bit 0: sample_0 .. sample_10 (12 bits each), start_request.
  input  wire logic [lfpd_pkg::IN_TDATA_W-1:0]     s_tdata,
  input  wire logic                                s_tvalid,
  output logic                                     s_tready,
  // Fields from bit 0: left_duty, left_pin, right_duty, right_pin,
  // line_found, side_class, position_error, running.
  output logic [lfpd_pkg::OUT_TDATA_W-1:0]         m_tdata,
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  input  wire logic                                cfg_we,
  input  wire logic [lfpd_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [lfpd_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

  localparam int SAMPLES_W = lfpd_pkg::SENSOR_COUNT * lfpd_pkg::SAMPLE_BITS;

  logic                          in_valid;
  logic [lfpd_pkg::IN_BITS-1:0]  in_data;
  logic                          advance;
  lfpd_pkg::cfg_t                cfg;
  lfpd_pkg::line_hit_t           hit;
  lfpd_pkg::result_t             result;

  // The input register moves on when the result register is free or drains.
  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_data <= s_tdata[lfpd_pkg::IN_BITS-1:0];
    end
  end

  lfpd_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  lfpd_line_decode u_decode (
    .samples   (in_data[SAMPLES_W-1:0]),
    .threshold (cfg.detect_threshold),
    .hit       (hit)
  );

  lfpd_pid_drive u_pid (
    .clk           (clk),
    .rst           (rst),
    .commit        (advance),
    .cfg           (cfg),
    .hit           (hit),
    .start_request (in_data[SAMPLES_W]),
    .result        (result)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= lfpd_pkg::OUT_TDATA_W'(result);
    end
  end

endmodule

`default_nettype wire

@@ tb/sv/tb.sv @@
// Self-checking testbench for the line follower PID drive core.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lfpd_pkg::*;

  localparam int START_BIT   = SENSOR_COUNT * SAMPLE_BITS;
  localparam int STALL_LIMIT = 5000;

  // One step of the directed script: a register write or one control tick.
  typedef struct {
    logic                     is_reg;
    cfg_index_t               reg_sel;
    logic [CFG_DATA_BITS-1:0] reg_val;
    logic [SENSOR_COUNT-1:0]  lit;
    logic [SAMPLE_BITS-1:0]   bright;
    logic [SAMPLE_BITS-1:0]   dark;
    logic                     start;
    logic                     typed;
    result_t                  want;
  } script_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  // Fields from bit 0: sample_0 .. sample_10 (12 bits each), start_request.
  logic [IN_TDATA_W-1:0]     s_tdata = '0;
  logic                      s_tvalid = 1'b0;
  logic                      s_tready;
  // Fields from bit 0: left_duty, left_pin, right_duty, right_pin,
  // line_found, side_class, position_error, running.
  logic [OUT_TDATA_W-1:0]    m_tdata;
  logic                      m_tvalid;
  logic                      m_tready = 1'b0;
  logic                      cfg_we = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_data = '0;

  // Mirror of the controller state and register set.
  cfg_t   regs;
  mode_t  run_mode;
  side_t  side_now;
  int     err_now;
  int     err_last;
  int     err_sum;
  drive_t left_cmd;
  drive_t right_cmd;

  result_t     expected_drive[$];
  script_row_t script[$];
  result_t     got_drive;
  result_t     want_drive;
  result_t     run_dark;
  result_t     run_centered;

  int gap_pct = 0;
  int stall_pct = 0;
  int ticks_sent = 0;
  int results_seen = 0;
  int mismatch_count = 0;
  int phase_count = 0;
  int quiet_cycles = 0;

  line_follower_pid_drive_core DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #6 clk = ~clk;

  // Prints one line per mismatch, up to a cap, and counts every one.
  task automatic report_mismatch(string what, longint got, longint want);
    mismatch_count++;
    if (mismatch_count <= 30) begin
      $display("%s on result %0d: got %0d, expected %0d", what, results_seen, got, want);
    end
  endtask

  // Builds a tick word: lit sensors at one level, the rest at another.
  function automatic logic [IN_TDATA_W-1:0] sensor_word(logic [SENSOR_COUNT-1:0] lit,
                                                        logic [SAMPLE_BITS-1:0] bright,
                                                        logic [SAMPLE_BITS-1:0] dark,
                                                        logic start);
    logic [IN_TDATA_W-1:0] word;
    int i;
    word = '0;
    for (i = 0; i < SENSOR_COUNT; i++) begin
      word[i*SAMPLE_BITS +: SAMPLE_BITS] = lit[i] ? bright : dark;
    end
    word[START_BIT] = start;
    return word;
  endfunction

  // Clamps a signed speed to a duty and a direction pin; zero keeps the pin.
  function automatic drive_t motor_command(longint speed, logic fwd_level, drive_t held);
    drive_t cmd;
    longint lim;
    longint mag;
    cmd = held;
    lim = longint'(regs.speed_limit);
    if (speed == 0) begin
      cmd.duty = '0;
    end else if (speed > 0 && lim > 0) begin
      cmd.duty = DUTY_BITS'((speed >= lim) ? lim : speed);
      cmd.pin  = fwd_level;
    end else begin
      mag = (speed > 0) ? 0 : -speed;
      cmd.duty = DUTY_BITS'((mag >= lim) ? lim : mag);
      cmd.pin  = ~fwd_level;
    end
    return cmd;
  endfunction

  // Advances the controller mirror by one tick and returns its result.
  function automatic result_t predict_drive(logic [IN_TDATA_W-1:0] word);
    result_t                 r;
    logic [SENSOR_COUNT-1:0] seen;
    int                      i;
    int                      e;
    longint                  acc;
    longint                  u;
    longint                  base;
    longint                  lim;
    r = '0;
    for (i = 0; i < SENSOR_COUNT; i++) begin
      seen[i] = word[i*SAMPLE_BITS +: SAMPLE_BITS] > regs.detect_threshold;
    end
    base = longint'(regs.base_speed);
    lim  = longint'(regs.speed_limit);
    case (run_mode)
      MODE_RUN: begin
        r.running = 1'b1;
        if (seen != '0) begin
          // Later rules win: left singles, left pairs, right singles,
          // right pairs, then the center combinations.
          e = err_now;
          for (i = 1; i <= 5; i++) if (seen[2*i-1]) e = -2 * i;
          for (i = 1; i <= 4; i++) if (seen[2*i-1] && seen[2*i+1]) e = -(2 * i + 1);
          for (i = 1; i <= 5; i++) if (seen[2*i]) e = 2 * i;
          for (i = 1; i <= 4; i++) if (seen[2*i] && seen[2*i+2]) e = 2 * i + 1;
          if (seen[0]) e = 0;
          if (seen[0] && seen[1]) e = -1;
          if (seen[0] && seen[2]) e = 1;
          err_now = e;
          if (e >= -4 && e <= 4) side_now = SIDE_CENTER;
          else if (e >= 5) side_now = SIDE_LEFT;
          else side_now = SIDE_RIGHT;
          r.line_found = 1'b1;
          // PID update with a saturating 16-bit integral.
          err_sum = err_sum + e;
          if (err_sum > 32767) err_sum = 32767;
          if (err_sum < -32768) err_sum = -32768;
          acc = longint'(regs.gain_p) * e + longint'(regs.gain_i) * err_sum
              + longint'(regs.gain_d) * longint'(e - err_last);
          u = acc / 256;
          left_cmd  = motor_command(base - u, 1'b1, left_cmd);
          right_cmd = motor_command(base + u, 1'b0, right_cmd);
          err_last = e;
        end else begin
          // Line lost: search by the side it was last seen on.
          case (side_now)
            SIDE_LEFT: begin
              left_cmd  = motor_command(lim, 1'b1, left_cmd);
              right_cmd = motor_command(-lim, 1'b0, right_cmd);
            end
            SIDE_RIGHT: begin
              left_cmd  = motor_command(-lim, 1'b1, left_cmd);
              right_cmd = motor_command(lim, 1'b0, right_cmd);
            end
            default: begin
              left_cmd  = motor_command(base, 1'b1, left_cmd);
              right_cmd = motor_command(base, 1'b0, right_cmd);
            end
          endcase
        end
      end
      MODE_STARTING: begin
        run_mode = MODE_RUN;
      end
      default: begin
        left_cmd.duty  = '0;
        right_cmd.duty = '0;
        run_mode = word[START_BIT] ? MODE_STARTING : MODE_STOPPED;
      end
    endcase
    r.left_duty      = left_cmd.duty;
    r.left_pin       = left_cmd.pin;
    r.right_duty     = right_cmd.duty;
    r.right_pin      = right_cmd.pin;
    r.side_class     = side_now;
    r.position_error = err_now[ERR_BITS-1:0];
    return r;
  endfunction

  // Random tick: mostly line patterns, some lost-line, some raw noise.
  function automatic logic [IN_TDATA_W-1:0] random_tick();
    logic [SENSOR_COUNT-1:0] lit;
    logic [IN_TDATA_W-1:0]   word;
    int                      pick;
    int                      k;
    int                      i;
    int                      thr;
    thr  = int'(regs.detect_threshold);
    pick = $urandom_range(0, 99);
    lit  = '0;
    if (pick < 60) begin
      k = $urandom_range(0, SENSOR_COUNT - 1);
      lit[k] = 1'b1;
      if ($urandom_range(0, 1) == 1) begin
        if (k == 0) lit[$urandom_range(1, 2)] = 1'b1;
        else if (k + 2 < SENSOR_COUNT) lit[k + 2] = 1'b1;
        else lit[k - 2] = 1'b1;
      end
    end else if (pick >= 75) begin
      lit = SENSOR_COUNT'($urandom);
    end
    word = '0;
    for (i = 0; i < SENSOR_COUNT; i++) begin
      if (pick >= 90) word[i*SAMPLE_BITS +: SAMPLE_BITS] = SAMPLE_BITS'($urandom);
      else if (lit[i] && thr < 4095)
        word[i*SAMPLE_BITS +: SAMPLE_BITS] = SAMPLE_BITS'($urandom_range(4095, thr + 1));
      else if (lit[i]) word[i*SAMPLE_BITS +: SAMPLE_BITS] = '1;
      else word[i*SAMPLE_BITS +: SAMPLE_BITS] = SAMPLE_BITS'($urandom_range(thr, 0));
    end
    word[START_BIT] = 1'($urandom_range(0, 1));
    return word;
  endfunction

  // Offers one tick, holds it until the transfer, then records its result.
  task automatic send_tick(logic [IN_TDATA_W-1:0] word, logic typed, result_t fixed_want);
    result_t predicted;
    while ($urandom_range(0, 99) < gap_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tdata  <= word;
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predicted = predict_drive(word);
    expected_drive.push_back(typed ? fixed_want : predicted);
    ticks_sent++;
  endtask

  // Stops offering ticks and waits for the block to drain.
  task automatic settle();
    s_tvalid <= 1'b0;
    while (expected_drive.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // One register write; the mirror takes the masked value.
  task automatic write_reg(cfg_index_t sel, logic [CFG_DATA_BITS-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= sel;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (sel)
      CFG_THRESHOLD:   regs.detect_threshold = val[THRESH_BITS-1:0];
      CFG_SPEED_LIMIT: regs.speed_limit = val[DUTY_BITS-1:0];
      CFG_BASE_SPEED:  regs.base_speed = val[DUTY_BITS-1:0];
      CFG_GAIN_P:      regs.gain_p = val[GAIN_BITS-1:0];
      CFG_GAIN_I:      regs.gain_i = val[GAIN_BITS-1:0];
      CFG_GAIN_D:      regs.gain_d = val[GAIN_BITS-1:0];
      default: ;
    endcase
  endtask

  // Writes the whole register set once the block is idle.
  task automatic load_regs(int thr, int mx, int base, int gp, int gi, int gd);
    settle();
    write_reg(CFG_THRESHOLD, CFG_DATA_BITS'(thr));
    write_reg(CFG_SPEED_LIMIT, CFG_DATA_BITS'(mx));
    write_reg(CFG_BASE_SPEED, CFG_DATA_BITS'(base));
    write_reg(CFG_GAIN_P, CFG_DATA_BITS'(gp));
    write_reg(CFG_GAIN_I, CFG_DATA_BITS'(gi));
    write_reg(CFG_GAIN_D, CFG_DATA_BITS'(gd));
    phase_count++;
  endtask

  // A stretch of random ticks under one idling pattern.
  task automatic run_phase(int count, int sender_gap, int receiver_stall);
    int n;
    gap_pct   = sender_gap;
    stall_pct = receiver_stall;
    for (n = 0; n < count; n++) send_tick(random_tick(), 1'b0, '0);
  endtask

  function automatic script_row_t tick_row(logic [SENSOR_COUNT-1:0] lit, int bright, int dark,
                                           logic start);
    script_row_t row;
    row.is_reg  = 1'b0;
    row.reg_sel = CFG_THRESHOLD;
    row.reg_val = '0;
    row.lit     = lit;
    row.bright  = SAMPLE_BITS'(bright);
    row.dark    = SAMPLE_BITS'(dark);
    row.start   = start;
    row.typed   = 1'b0;
    row.want    = '0;
    return row;
  endfunction

  function automatic script_row_t fixed_row(logic [SENSOR_COUNT-1:0] lit, int bright, int dark,
                                            logic start, result_t want);
    script_row_t row;
    row = tick_row(lit, bright, dark, start);
    row.typed = 1'b1;
    row.want  = want;
    return row;
  endfunction

  function automatic script_row_t reg_row(cfg_index_t sel, logic [CFG_DATA_BITS-1:0] val);
    script_row_t row;
    row = tick_row('0, 0, 0, 1'b0);
    row.is_reg  = 1'b1;
    row.reg_sel = sel;
    row.reg_val = val;
    return row;
  endfunction

  // Result checker and receiver stall pattern.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got_drive = result_t'(m_tdata[OUT_BITS-1:0]);
      results_seen++;
      if (expected_drive.size() == 0) begin
        report_mismatch("result with nothing pending", longint'(got_drive), 0);
      end else begin
        want_drive = expected_drive.pop_front();
        if (got_drive.left_duty != want_drive.left_duty)
          report_mismatch("left_duty", got_drive.left_duty, want_drive.left_duty);
        if (got_drive.left_pin != want_drive.left_pin)
          report_mismatch("left_pin", got_drive.left_pin, want_drive.left_pin);
        if (got_drive.right_duty != want_drive.right_duty)
          report_mismatch("right_duty", got_drive.right_duty, want_drive.right_duty);
        if (got_drive.right_pin != want_drive.right_pin)
          report_mismatch("right_pin", got_drive.right_pin, want_drive.right_pin);
        if (got_drive.line_found != want_drive.line_found)
          report_mismatch("line_found", got_drive.line_found, want_drive.line_found);
        if (got_drive.side_class != want_drive.side_class)
          report_mismatch("side_class", got_drive.side_class, want_drive.side_class);
        if (got_drive.position_error != want_drive.position_error)
          report_mismatch("position_error", got_drive.position_error,
                          want_drive.position_error);
        if (got_drive.running != want_drive.running)
          report_mismatch("running", got_drive.running, want_drive.running);
      end
    end
    m_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // Watchdog: ends the run when no transfer happens for too long.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == STALL_LIMIT) begin
      $display("Timeout: no transfer for %0d cycles", STALL_LIMIT);
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Stimulus sequence.
  initial begin
    // Mirror starts at the reset state and register defaults.
    regs = '{detect_threshold: THRESH_RESET, speed_limit: MAX_RESET, base_speed: BASE_RESET,
             gain_p: GAIN_P_RESET, gain_i: GAIN_I_RESET, gain_d: GAIN_D_RESET};
    run_mode  = MODE_STOPPED;
    side_now  = SIDE_CENTER;
    err_now   = 0;
    err_last  = 0;
    err_sum   = 0;
    left_cmd  = '0;
    right_cmd = '0;

    run_dark = '0;
    run_dark.running = 1'b1;
    run_centered = run_dark;
    run_centered.line_found = 1'b1;

    // Directed script. Sensor bits: 0 center, odd left, even right,
    // outermost at 9 and 10.
    script.push_back(fixed_row(11'h7FF, 4095, 0, 1'b0, '0));   // stopped, no start
    script.push_back(fixed_row(11'h000, 4095, 0, 1'b0, '0));   // stopped, all dark
    script.push_back(fixed_row(11'h7FF, 4095, 0, 1'b1, '0));   // start request
    script.push_back(fixed_row(11'h7FF, 4095, 0, 1'b1, '0));   // starting holds
    script.push_back(fixed_row(11'h000, 0, 4000, 1'b0, run_dark));        // at threshold
    script.push_back(fixed_row(11'h001, 4001, 4000, 1'b0, run_centered)); // center only
    script.push_back(tick_row(11'h002, 4001, 4000, 1'b1));
    script.push_back(tick_row(11'h004, 4095, 0, 1'b0));
    script.push_back(tick_row(11'h003, 4095, 0, 1'b0));
    script.push_back(tick_row(11'h005, 4095, 0, 1'b0));
    script.push_back(tick_row(11'h00A, 4095, 0, 1'b0));
    script.push_back(tick_row(11'h014, 4095, 0, 1'b0));
    script.push_back(tick_row(11'h008, 4095, 0, 1'b0));
    script.push_back(tick_row(11'h010, 4095, 0, 1'b0));
    script.push_back(tick_row(11'h028, 4095, 0, 1'b0));
    script.push_back(tick_row(11'h040, 4095, 0, 1'b0));
    script.push_back(tick_row(11'h280, 4095, 0, 1'b0));
    script.push_back(tick_row(11'h500, 4095, 0, 1'b0));
    script.push_back(tick_row(11'h200, 4095, 0, 1'b0));         // outer left
    script.push_back(tick_row(11'h000, 4095, 0, 1'b0));         // lost, right side
    script.push_back(tick_row(11'h400, 4095, 0, 1'b0));         // outer right
    script.push_back(tick_row(11'h000, 4095, 0, 1'b0));         // lost, left side
    script.push_back(tick_row(11'h7FF, 4095, 0, 1'b0));         // all sensors
    // Zero max speed with a forward command; upper data bits are dropped.
    script.push_back(reg_row(CFG_SPEED_LIMIT, '0));
    script.push_back(reg_row(CFG_BASE_SPEED, '1));
    script.push_back(tick_row(11'h001, 4095, 0, 1'b0));
    script.push_back(reg_row(CFG_THRESHOLD, '1));
    script.push_back(tick_row(11'h7FF, 4095, 0, 1'b0));         // nothing above 4095

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (script[k]) begin
      if (script[k].is_reg) begin
        settle();
        write_reg(script[k].reg_sel, script[k].reg_val);
      end else begin
        send_tick(sensor_word(script[k].lit, script[k].bright, script[k].dark,
                              script[k].start), script[k].typed, script[k].want);
      end
    end

    // Random phases across register settings, extremes among them.
    load_regs(2048, 455, 300, 26112, 256, 58624);
    run_phase(200, 0, 0);
    load_regs(0, 1023, 1023, 65535, 65535, 65535);
    run_phase(200, 64, 0);
    load_regs(4094, 1, 0, 0, 0, 0);
    run_phase(150, 0, 64);
    load_regs(1000, 600, 500, 512, 3, 1024);
    run_phase(250, 7, 7);
    load_regs(3000, 0, 200, 300, 10, 4000);
    run_phase(100, 0, 0);
    load_regs(3500, 800, 100, 40000, 700, 12000);
    run_phase(300, 7, 7);

    settle();
    $display("Run covered %0d control ticks over %0d register settings, %0d results checked.",
             ticks_sent, phase_count + 1, results_seen);
    $display("Stopped, starting and run modes, lost-line search and duty clamping were hit.");
    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
